// ===== rtl/core/svm_pkg.sv =====
// shared types and constants of the sample voice mixer
package svm_pkg;

  localparam int SMP_W    = 16;
  localparam int POS_W    = 33;
  localparam int FRAC_W   = 16;
  localparam int IDX_W    = POS_W - FRAC_W;
  localparam int STEP_W   = 19;
  localparam int GAIN_W   = 16;
  localparam int LEN_W    = 17;
  localparam int PROD_W   = 34;
  localparam int TERM_W   = PROD_W + GAIN_W + 1;
  localparam int RND_SH   = 31;
  localparam int MIX_MAX  = 32767;
  localparam int MIX_MIN  = -32768;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRIG = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } svm_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_RD1,
    ST_MUL,
    ST_GAIN,
    ST_ACC,
    ST_DONE
  } svm_state_t;

  typedef struct packed {
    logic clr;
    logic cap_s0;
    logic mul_en;
    logic gain_en;
    logic acc_en;
  } svm_dp_ctrl_t;

endpackage

// ===== rtl/core/svm_if.sv =====
// request and result channel interfaces of the sample voice mixer
interface svm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  sound_sel;
  logic [15:0] sample_addr;
  logic signed [15:0] sample_value;
  logic        is_last_sample;
  logic [15:0] volume;
  logic [18:0] step;

  modport source (
    output valid, cmd, sound_sel, sample_addr, sample_value, is_last_sample,
           volume, step,
    input  ready
  );
  modport sink (
    input  valid, cmd, sound_sel, sample_addr, sample_value, is_last_sample,
           volume, step,
    output ready
  );
endinterface

interface svm_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] mix_out;

  modport source (output valid, mix_out, input ready);
  modport sink (input valid, mix_out, output ready);
endinterface

// ===== rtl/core/svm_ram.sv =====
// generic single write port ram with registered read
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/core/svm_mix_dp.sv =====
// interpolation, gain and accumulation datapath with round and clamp
module svm_mix_dp #(
  parameter int MAX_VOICES = 16
) (
  input  logic                              clk,
  input  svm_pkg::svm_dp_ctrl_t             ctrl,
  input  logic signed [svm_pkg::SMP_W-1:0]  smp,
  input  logic [svm_pkg::FRAC_W-1:0]        frac,
  input  logic                              zero,
  input  logic                              flat,
  input  logic [svm_pkg::GAIN_W-1:0]        gain,
  output logic signed [svm_pkg::SMP_W-1:0]  mix
);
  localparam int SUM_W = svm_pkg::TERM_W + $clog2(MAX_VOICES + 1);
  localparam int DIF_W = svm_pkg::SMP_W + 1;
  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(64'sd1073741824);
  localparam logic signed [SUM_W-1:0] MIX_HI = SUM_W'(svm_pkg::MIX_MAX);
  localparam logic signed [SUM_W-1:0] MIX_LO = SUM_W'(svm_pkg::MIX_MIN);

  logic signed [svm_pkg::SMP_W-1:0]  s0_r;
  logic signed [DIF_W-1:0]           diff;
  logic signed [DIF_W-1:0]           frac_s;
  logic signed [svm_pkg::PROD_W-1:0] prod_c;
  logic signed [svm_pkg::PROD_W-1:0] prod_r;
  logic signed [svm_pkg::PROD_W-1:0] interp;
  logic signed [svm_pkg::GAIN_W:0]   gain_s;
  logic signed [svm_pkg::TERM_W-1:0] term_c;
  logic signed [svm_pkg::TERM_W-1:0] term_r;
  logic signed [SUM_W-1:0]           sum_r;
  logic signed [SUM_W-1:0]           rnd;
  logic signed [SUM_W-1:0]           shr;

  always_comb begin
    diff   = flat ? '0 : (DIF_W'(smp) - DIF_W'(s0_r));
    frac_s = $signed({1'b0, frac});
    prod_c = diff * frac_s;
    interp = zero ? '0
                  : ($signed({{(svm_pkg::PROD_W - svm_pkg::SMP_W - svm_pkg::FRAC_W){s0_r[svm_pkg::SMP_W-1]}},
                              s0_r, {svm_pkg::FRAC_W{1'b0}}}) + prod_r);
    gain_s = $signed({1'b0, gain});
    term_c = interp * gain_s;
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap_s0) begin
      s0_r <= smp;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_c;
    end
    if (ctrl.gain_en) begin
      term_r <= term_c;
    end
    if (ctrl.clr) begin
      sum_r <= '0;
    end else if (ctrl.acc_en) begin
      sum_r <= sum_r + SUM_W'(term_r);
    end
  end

  // round half up, then clamp to q1.15
  always_comb begin
    rnd = sum_r + HALF;
    shr = rnd >>> svm_pkg::RND_SH;
    if (shr > MIX_HI) begin
      mix = svm_pkg::SMP_W'(svm_pkg::MIX_MAX);
    end else if (shr < MIX_LO) begin
      mix = svm_pkg::SMP_W'(svm_pkg::MIX_MIN);
    end else begin
      mix = shr[svm_pkg::SMP_W-1:0];
    end
  end
endmodule

// ===== rtl/core/sample_voice_mixer_top.sv =====
// top level of the sample voice mixer: command decode, voice sequencer, memories
//
// in_bus carries requests: load writes one sample into a sound memory (and sets
// the sound length when is_last_sample is high), trigger starts the lowest idle
// voice on a sound, tick mixes one output frame. out_bus carries one mix_out
// result per tick. load and trigger are accepted back to back.
// a tick visits every voice slot in the scan state, and an active voice then
// passes through the fetch, rd1, mul, gain and acc states, which cover the voice
// memory read, two sample memory reads on its single read port, the
// interpolation multiply, the gain multiply and the accumulation.
// no request is taken while a tick is in progress.
// reset idles all voices and empties all sounds; sample memory contents are
// not cleared and no clearing pass runs.
// the result sits in an output register: requests keep flowing while it waits,
// but the next tick holds its finished result until the previous one is taken.
module sample_voice_mixer_top #(
  parameter int MAX_VOICES  = 16,
  parameter int NUM_SOUNDS  = 4,
  parameter int SOUND_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  svm_in_if.sink      in_bus,
  svm_out_if.source   out_bus
);
  localparam int VOICE_W   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int SND_W     = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
  localparam int MEM_DEPTH = NUM_SOUNDS * SOUND_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int GAIN_LO   = 0;
  localparam int STEP_LO   = svm_pkg::GAIN_W;
  localparam int POS_LO    = STEP_LO + svm_pkg::STEP_W;
  localparam int SND_LO    = POS_LO + svm_pkg::POS_W;
  localparam int VRAM_W    = SND_LO + SND_W;

  svm_pkg::svm_state_t state_r, state_nxt;
  svm_pkg::svm_dp_ctrl_t dp_ctrl;

  logic [VOICE_W-1:0]               v_r;
  logic [MAX_VOICES-1:0]            active_r;
  logic [svm_pkg::LEN_W-1:0]        sound_len_r [NUM_SOUNDS];
  logic [SND_W-1:0]                 vsnd_r;
  logic [svm_pkg::POS_W-1:0]        vpos_r;
  logic [svm_pkg::STEP_W-1:0]       vstep_r;
  logic [svm_pkg::GAIN_W-1:0]       vgain_r;
  logic [svm_pkg::LEN_W-1:0]        vlen_r;
  logic [svm_pkg::IDX_W-1:0]        i0_r;
  logic                             zero_r;
  logic                             flat_r;
  logic                             out_valid_r;
  logic signed [svm_pkg::SMP_W-1:0] out_mix_r;

  logic                             in_acc;
  logic                             sel_ok;
  logic                             addr_ok;
  logic                             load_we;
  logic                             trig_we;
  logic                             free_found;
  logic [VOICE_W-1:0]               free_idx;
  logic [SND_W-1:0]                 len_idx;
  logic [svm_pkg::LEN_W-1:0]        len_rd;
  logic [svm_pkg::GAIN_W-1:0]       gain_sat;
  logic                             last_voice;
  logic [svm_pkg::POS_W-1:0]        pos_sum;
  logic                             pos_end;
  logic [svm_pkg::IDX_W:0]          i0_inc;
  logic                             load_out;

  logic [VRAM_W-1:0]                vram_rdata;
  logic [VRAM_W-1:0]                vram_wdata;
  logic [VOICE_W-1:0]               vram_waddr;
  logic                             vram_we;
  logic [SND_W-1:0]                 rd_snd;
  logic [svm_pkg::POS_W-1:0]        rd_pos;
  logic [svm_pkg::IDX_W-1:0]        rd_i0;
  logic                             rd_zero;
  logic                             rd_flat;

  logic [MEM_AW-1:0]                smp_waddr;
  logic [MEM_AW-1:0]                smp_raddr;
  logic [svm_pkg::SMP_W-1:0]        smp_rdata;
  logic signed [svm_pkg::SMP_W-1:0] mix;

  // request decode
  always_comb begin
    in_acc   = in_bus.valid && in_bus.ready;
    sel_ok   = 32'(in_bus.sound_sel) < NUM_SOUNDS;
    addr_ok  = 32'(in_bus.sample_addr) < SOUND_DEPTH;
    load_we  = in_acc && (in_bus.cmd == svm_pkg::CMD_LOAD) && sel_ok && addr_ok;
    len_idx  = (state_r == svm_pkg::ST_IDLE) ? SND_W'(in_bus.sound_sel) : rd_snd;
    len_rd   = sound_len_r[len_idx];
    trig_we  = in_acc && (in_bus.cmd == svm_pkg::CMD_TRIG) && sel_ok &&
               (len_rd != '0) && free_found;
    gain_sat = (in_bus.volume > svm_pkg::GAIN_ONE) ? svm_pkg::GAIN_ONE : in_bus.volume;
    smp_waddr = MEM_AW'(MEM_AW'(in_bus.sound_sel) * MEM_AW'(SOUND_DEPTH) +
                        MEM_AW'(in_bus.sample_addr));
  end

  // lowest idle voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_VOICES - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = VOICE_W'(i);
      end
    end
  end

  // fetched voice word and its flags
  always_comb begin
    rd_snd  = vram_rdata[SND_LO +: SND_W];
    rd_pos  = vram_rdata[POS_LO +: svm_pkg::POS_W];
    rd_i0   = rd_pos[svm_pkg::POS_W-1:svm_pkg::FRAC_W];
    rd_zero = rd_i0 >= len_rd;
    rd_flat = ({1'b0, rd_i0} + (svm_pkg::IDX_W+1)'(1)) >= {1'b0, len_rd};
    i0_inc  = {1'b0, i0_r} + (svm_pkg::IDX_W+1)'(1);
    pos_sum = vpos_r + svm_pkg::POS_W'(vstep_r);
    pos_end = pos_sum >= {vlen_r, {svm_pkg::FRAC_W{1'b0}}};
    last_voice = v_r == VOICE_W'(MAX_VOICES - 1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svm_pkg::ST_IDLE: begin
        if (in_acc && (in_bus.cmd == svm_pkg::CMD_TICK)) begin
          state_nxt = svm_pkg::ST_SCAN;
        end
      end
      svm_pkg::ST_SCAN: begin
        if (active_r[v_r]) begin
          state_nxt = svm_pkg::ST_FETCH;
        end else if (last_voice) begin
          state_nxt = svm_pkg::ST_DONE;
        end
      end
      svm_pkg::ST_FETCH: state_nxt = svm_pkg::ST_RD1;
      svm_pkg::ST_RD1:   state_nxt = svm_pkg::ST_MUL;
      svm_pkg::ST_MUL:   state_nxt = svm_pkg::ST_GAIN;
      svm_pkg::ST_GAIN:  state_nxt = svm_pkg::ST_ACC;
      svm_pkg::ST_ACC: begin
        state_nxt = last_voice ? svm_pkg::ST_DONE : svm_pkg::ST_SCAN;
      end
      svm_pkg::ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          state_nxt = svm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = svm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_bus.ready   = state_r == svm_pkg::ST_IDLE;
    dp_ctrl.clr    = in_acc && (in_bus.cmd == svm_pkg::CMD_TICK);
    dp_ctrl.cap_s0 = state_r == svm_pkg::ST_RD1;
    dp_ctrl.mul_en = state_r == svm_pkg::ST_MUL;
    dp_ctrl.gain_en = state_r == svm_pkg::ST_GAIN;
    dp_ctrl.acc_en = state_r == svm_pkg::ST_ACC;
    load_out       = (state_r == svm_pkg::ST_DONE) && (!out_valid_r || out_bus.ready);
    if (state_r == svm_pkg::ST_FETCH) begin
      smp_raddr = MEM_AW'(MEM_AW'(rd_snd) * MEM_AW'(SOUND_DEPTH) + MEM_AW'(rd_i0));
    end else begin
      smp_raddr = MEM_AW'(MEM_AW'(vsnd_r) * MEM_AW'(SOUND_DEPTH) + MEM_AW'(i0_inc));
    end
    if (state_r == svm_pkg::ST_ACC) begin
      vram_we    = 1'b1;
      vram_waddr = v_r;
      vram_wdata = {vsnd_r, pos_sum, vstep_r, vgain_r};
    end else begin
      vram_we    = trig_we;
      vram_waddr = free_idx;
      vram_wdata = {SND_W'(in_bus.sound_sel), svm_pkg::POS_W'(0), in_bus.step, gain_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svm_pkg::ST_IDLE;
      v_r         <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_SOUNDS; s++) begin
        sound_len_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (dp_ctrl.clr) begin
        v_r <= '0;
      end else if (((state_r == svm_pkg::ST_SCAN) && !active_r[v_r] && !last_voice) ||
                   ((state_r == svm_pkg::ST_ACC) && !last_voice)) begin
        v_r <= v_r + VOICE_W'(1);
      end
      if (trig_we) begin
        active_r[free_idx] <= 1'b1;
      end
      if ((state_r == svm_pkg::ST_ACC) && pos_end) begin
        active_r[v_r] <= 1'b0;
      end
      if (load_we && in_bus.is_last_sample) begin
        sound_len_r[SND_W'(in_bus.sound_sel)] <=
          svm_pkg::LEN_W'(in_bus.sample_addr) + svm_pkg::LEN_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == svm_pkg::ST_FETCH) begin
      vsnd_r  <= rd_snd;
      vpos_r  <= rd_pos;
      vstep_r <= vram_rdata[STEP_LO +: svm_pkg::STEP_W];
      vgain_r <= vram_rdata[GAIN_LO +: svm_pkg::GAIN_W];
      vlen_r  <= len_rd;
      i0_r    <= rd_i0;
      zero_r  <= rd_zero;
      flat_r  <= rd_flat;
    end
    if (load_out) begin
      out_mix_r <= mix;
    end
  end

  svm_ram #(
    .WIDTH (svm_pkg::SMP_W),
    .DEPTH (MEM_DEPTH)
  ) u_smp_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (smp_waddr),
    .wdata (in_bus.sample_value),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  svm_ram #(
    .WIDTH (VRAM_W),
    .DEPTH (MAX_VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (v_r),
    .rdata (vram_rdata)
  );

  svm_mix_dp #(
    .MAX_VOICES (MAX_VOICES)
  ) u_mix_dp (
    .clk   (clk),
    .ctrl  (dp_ctrl),
    .smp   ($signed(smp_rdata)),
    .frac  (vpos_r[svm_pkg::FRAC_W-1:0]),
    .zero  (zero_r),
    .flat  (flat_r),
    .gain  (vgain_r),
    .mix   (mix)
  );

  assign out_bus.valid   = out_valid_r;
  assign out_bus.mix_out = out_mix_r;

  a_tick_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_bus.cmd == svm_pkg::CMD_TICK)) |=> !in_bus.ready)
    else $error("request taken right after a tick");

  a_acc_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == svm_pkg::ST_ACC) |-> active_r[v_r])
    else $error("write back to an idle voice");

  a_vram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(trig_we && (state_r == svm_pkg::ST_ACC)))
    else $error("trigger and write back collide on voice memory");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == svm_pkg::ST_DONE))
    else $error("result loaded outside the done state");
endmodule

// ===== test/svm_mix_checker.sv =====
// checker for the sample voice mixer: tracks requests, predicts each mixed frame, compares results
`timescale 1ns / 100ps

module svm_mix_checker #(
  parameter int N_VOICE = 16,
  parameter int N_SOUND = 4,
  parameter int DEPTH   = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  logic [1:0]                        in_sound_sel,
  input  logic [15:0]                       in_sample_addr,
  input  logic signed [svm_pkg::SMP_W-1:0]  in_sample_value,
  input  logic                              in_is_last_sample,
  input  logic [svm_pkg::GAIN_W-1:0]        in_volume,
  input  logic [svm_pkg::STEP_W-1:0]        in_step,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [svm_pkg::SMP_W-1:0]  out_mix_out,
  output int                                err_count,
  output int                                pending,
  output int                                frames_seen,
  output int                                voices_started,
  output int                                trig_dropped,
  output int                                clipped
);

  logic signed [svm_pkg::SMP_W-1:0] snd_mem [N_SOUND][DEPTH];
  logic [svm_pkg::LEN_W-1:0]        snd_len [N_SOUND];
  logic                             vc_on   [N_VOICE];
  logic [1:0]                       vc_snd  [N_VOICE];
  logic [svm_pkg::POS_W-1:0]        vc_pos  [N_VOICE];
  logic [svm_pkg::STEP_W-1:0]       vc_step [N_VOICE];
  logic [svm_pkg::GAIN_W-1:0]       vc_gain [N_VOICE];

  logic signed [svm_pkg::SMP_W-1:0] mix_expect_q [$];

  function automatic longint voice_tap(logic [1:0] s, logic [svm_pkg::POS_W-1:0] pos);
    logic [svm_pkg::IDX_W-1:0] i0;
    longint f, a, b;
    i0 = pos[svm_pkg::POS_W-1:svm_pkg::FRAC_W];
    f  = pos[svm_pkg::FRAC_W-1:0];
    if (i0 >= snd_len[s]) return 0;
    a = snd_mem[s][i0[15:0]];
    if (i0 + 1 >= snd_len[s]) return a * 65536;
    b = snd_mem[s][i0[15:0] + 1];
    return a * (65536 - f) + b * f;
  endfunction

  task automatic mix_tick(output logic signed [svm_pkg::SMP_W-1:0] mix, output bit clip);
    longint sum, r, g;
    logic [1:0] s;
    sum = 0;
    for (int v = 0; v < N_VOICE; v++) begin
      if (vc_on[v]) begin
        s = vc_snd[v];
        g = vc_gain[v];
        sum += voice_tap(s, vc_pos[v]) * g;
        vc_pos[v] = vc_pos[v] + vc_step[v];
        if (vc_pos[v] >= {snd_len[s], 16'h0000}) vc_on[v] = 1'b0;
      end
    end
    r = (sum + 64'sd1073741824) >>> svm_pkg::RND_SH;
    clip = (r > svm_pkg::MIX_MAX) || (r < svm_pkg::MIX_MIN);
    if (r > svm_pkg::MIX_MAX) begin
      r = svm_pkg::MIX_MAX;
    end else if (r < svm_pkg::MIX_MIN) begin
      r = svm_pkg::MIX_MIN;
    end
    mix = r[svm_pkg::SMP_W-1:0];
  endtask

  always @(posedge clk) begin
    logic signed [svm_pkg::SMP_W-1:0] want;
    logic signed [svm_pkg::SMP_W-1:0] mix;
    bit clip;
    bit found;
    if (!rst_n) begin
      for (int s = 0; s < N_SOUND; s++) snd_len[s] = '0;
      for (int v = 0; v < N_VOICE; v++) begin
        vc_on[v]   = 1'b0;
        vc_snd[v]  = '0;
        vc_pos[v]  = '0;
        vc_step[v] = '0;
        vc_gain[v] = '0;
      end
      mix_expect_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        frames_seen <= frames_seen + 1;
        if (mix_expect_q.size() == 0) begin
          if (err_count < 10)
            $display("%0t: mix_out %0d arrived with no frame pending", $time, out_mix_out);
          err_count <= err_count + 1;
        end else begin
          want = mix_expect_q.pop_front();
          if (out_mix_out !== want) begin
            if (err_count < 10)
              $display("%0t: mix_out mismatch, expected %0d, got %0d",
                       $time, want, out_mix_out);
            err_count <= err_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_cmd)
          svm_pkg::CMD_LOAD: begin
            if (in_sound_sel < N_SOUND && in_sample_addr < DEPTH) begin
              snd_mem[in_sound_sel][in_sample_addr] = in_sample_value;
              if (in_is_last_sample)
                snd_len[in_sound_sel] = svm_pkg::LEN_W'(in_sample_addr) + svm_pkg::LEN_W'(1);
            end
          end
          svm_pkg::CMD_TRIG: begin
            if (in_sound_sel < N_SOUND && snd_len[in_sound_sel] != 0) begin
              found = 1'b0;
              for (int v = 0; v < N_VOICE; v++) begin
                if (!found && !vc_on[v]) begin
                  found      = 1'b1;
                  vc_on[v]   = 1'b1;
                  vc_snd[v]  = in_sound_sel;
                  vc_pos[v]  = '0;
                  vc_step[v] = in_step;
                  vc_gain[v] = (in_volume > svm_pkg::GAIN_ONE) ? svm_pkg::GAIN_ONE : in_volume;
                end
              end
              if (found) begin
                voices_started <= voices_started + 1;
              end else begin
                trig_dropped <= trig_dropped + 1;
              end
            end
          end
          svm_pkg::CMD_TICK: begin
            mix_tick(mix, clip);
            mix_expect_q.insert(mix_expect_q.size(), mix);
            if (clip) clipped <= clipped + 1;
          end
          default: ;
        endcase
      end
      pending <= mix_expect_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// top of the sample voice mixer testbench: clock, reset, request stimulus, result pacing, verdict
`timescale 1ns / 100ps

module tb_top;

  localparam int SOUNDS      = 4;
  localparam int DEPTH       = 65536;
  localparam int ITEMS       = 950;
  localparam int CALM_AT     = 850;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN       = 120;

  logic clk;
  logic rst_n;

  svm_in_if  in_ch ();
  svm_out_if out_ch ();

  int chk_errors, chk_pending, frames_seen, voices_started, trig_dropped, clipped;

  bit wr_map [SOUNDS][DEPTH];
  int pref [SOUNDS];
  int snd_len_tb [SOUNDS];
  int sent_items;
  bit calm;
  bit held_off;

  sample_voice_mixer_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  svm_mix_checker i_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_cmd            (in_ch.cmd),
    .in_sound_sel      (in_ch.sound_sel),
    .in_sample_addr    (in_ch.sample_addr),
    .in_sample_value   (in_ch.sample_value),
    .in_is_last_sample (in_ch.is_last_sample),
    .in_volume         (in_ch.volume),
    .in_step           (in_ch.step),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_mix_out       (out_ch.mix_out),
    .err_count         (chk_errors),
    .pending           (chk_pending),
    .frames_seen       (frames_seen),
    .voices_started    (voices_started),
    .trig_dropped      (trig_dropped),
    .clipped           (clipped)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic send_req(input svm_pkg::svm_cmd_t c, input logic [1:0] s,
                          input logic [15:0] a, input logic signed [15:0] sv,
                          input logic lst, input logic [15:0] vol, input logic [18:0] stp);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.cmd            <= c;
    in_ch.sound_sel      <= s;
    in_ch.sample_addr    <= a;
    in_ch.sample_value   <= sv;
    in_ch.is_last_sample <= lst;
    in_ch.volume         <= vol;
    in_ch.step           <= stp;
    in_ch.valid          <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (c != svm_pkg::CMD_NOP) sent_items++;
    calm = (sent_items >= CALM_AT);
  endtask

  task automatic load_smp(input int s, input int a, input logic signed [15:0] v, input bit lst);
    send_req(svm_pkg::CMD_LOAD, s[1:0], a[15:0], v, lst, 16'($urandom), 19'($urandom));
    wr_map[s][a] = 1'b1;
    while (pref[s] < DEPTH && wr_map[s][pref[s]]) pref[s]++;
    if (lst) snd_len_tb[s] = a + 1;
  endtask

  task automatic trig_voice(input int s, input logic [15:0] vol, input logic [18:0] stp);
    send_req(svm_pkg::CMD_TRIG, s[1:0], 16'($urandom), 16'($urandom), 1'($urandom), vol, stp);
  endtask

  task automatic tick_frame();
    send_req(svm_pkg::CMD_TICK, 2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
             16'($urandom), 19'($urandom));
  endtask

  task automatic trig_rand();
    int s, r;
    logic [15:0] vol;
    logic [18:0] stp;
    r = $urandom_range(0, 9);
    vol = (r < 4) ? 16'($urandom_range(0, 32768)) :
          (r < 8) ? 16'($urandom) :
          (r == 8) ? svm_pkg::GAIN_ONE : 16'hFFFF;
    r = $urandom_range(0, 19);
    stp = (r < 15) ? 19'($urandom_range(1, 262144)) :
          (r < 19) ? 19'($urandom_range(8192, 65535)) : 19'd262144;
    s = $urandom_range(0, SOUNDS - 1);
    if ($urandom_range(0, 9) != 0)
      while (snd_len_tb[s] == 0) s = $urandom_range(0, SOUNDS - 1);
    trig_voice(s, vol, stp);
  endtask

  function automatic logic signed [15:0] rand_smp();
    case ($urandom_range(0, 19))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int pick, s, n, len;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= svm_pkg::CMD_NOP;
    in_ch.sound_sel      <= '0;
    in_ch.sample_addr    <= '0;
    in_ch.sample_value   <= '0;
    in_ch.is_last_sample <= 1'b0;
    in_ch.volume         <= '0;
    in_ch.step           <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // silent mix, trigger on an empty sound, unused command
    tick_frame();
    trig_voice(2, svm_pkg::GAIN_ONE, 19'd65536);
    send_req(svm_pkg::CMD_NOP, 2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
             16'($urandom), 19'($urandom));
    load_smp(0, 0, 16'sh7FFF, 1'b0);
    load_smp(0, 1, 16'sh8000, 1'b1);
    load_smp(1, 0, 16'sh8000, 1'b1);
    load_smp(3, 65535, 16'sh1234, 1'b0);
    // zero step holds forever, step of one with zero gain
    trig_voice(0, 16'd2000, 19'd0);
    trig_voice(1, 16'd0, 19'd1);
    trig_voice(0, svm_pkg::GAIN_ONE, 19'd32768);
    trig_voice(1, 16'hFFFF, 19'd262144);
    trig_voice(0, svm_pkg::GAIN_ONE, 19'd65536);
    repeat (3) tick_frame();
    // shorten a sound under a playing voice
    load_smp(2, 0, -16'sd20000, 1'b0);
    load_smp(2, 1, 16'sd15000, 1'b0);
    load_smp(2, 2, 16'sd30000, 1'b0);
    load_smp(2, 3, -16'sd5000, 1'b1);
    trig_voice(2, 16'd20000, 19'd65536);
    tick_frame();
    load_smp(2, 0, -16'sd20000, 1'b1);
    repeat (2) tick_frame();

    while (sent_items < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        s = $urandom_range(0, SOUNDS - 1);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        for (int i = 0; i < len; i++) load_smp(s, i, rand_smp(), i == len - 1);
      end else if (pick < 30) begin
        trig_rand();
      end else if (pick < 34) begin
        n = $urandom_range(12, 20);
        repeat (n) trig_rand();
      end else if (pick < 79) begin
        n = $urandom_range(1, 6);
        repeat (n) tick_frame();
      end else begin
        s = $urandom_range(0, SOUNDS - 1);
        case ($urandom_range(0, 2))
          0: send_req(svm_pkg::CMD_NOP, 2'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom), 16'($urandom), 19'($urandom));
          1: load_smp(s, $urandom_range(0, DEPTH - 1), rand_smp(), 1'b0);
          default: begin
            if (pref[s] > 0) begin
              load_smp(s, $urandom_range(0, pref[s] - 1), rand_smp(), 1'b1);
            end else begin
              load_smp(s, $urandom_range(0, DEPTH - 1), rand_smp(), 1'b0);
            end
          end
        endcase
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("run covered %0d requests and %0d mixed frames, %0d voices started",
             sent_items, frames_seen, voices_started);
    $display("%0d triggers dropped on a full voice table, %0d frames clipped, %s %0d cycles",
             trig_dropped, clipped, "one output stall of", HOLD_CYCLES);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held_off && !calm && frames_seen >= 30) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/svm_pkg.sv
rtl/core/svm_if.sv
rtl/core/svm_ram.sv
rtl/core/svm_mix_dp.sv
rtl/core/sample_voice_mixer_top.sv
test/svm_mix_checker.sv
test/tb_top.sv
